[hdl/dss_pkg.sv]
package dss_pkg;

  // Configuration register indexes
  localparam logic CFG_IOR_OUTSIDE = 1'b0;
  localparam logic CFG_IOR_INSIDE  = 1'b1;

  localparam logic [13:0] IOR_MIN         = 14'd4096;
  localparam logic [13:0] IOR_OUTSIDE_RST = 14'd4096;
  localparam logic [13:0] IOR_INSIDE_RST  = 14'd6144;

  // Stage schedule
  localparam int ST_PROD    = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_SIDE    = 3;
  localparam int ST_ETA0    = 4;
  localparam int ETA_BITS   = 18;
  localparam int ST_SN      = 4;
  localparam int ST_W       = 5;
  localparam int ST_SQ      = 6;
  localparam int ST_LEN2    = 7;
  localparam int ST_LEN0    = 8;
  localparam int LEN_STEPS  = 23;
  localparam int ST_NINIT   = ST_LEN0 + LEN_STEPS;
  localparam int ST_N0      = ST_NINIT + 1;
  localparam int QBITS      = 17;
  localparam int ST_NFIN    = ST_N0 + QBITS;
  localparam int ST_ETA2    = ST_ETA0 + ETA_BITS;
  localparam int ST_SIN2T   = ST_ETA2 + 1;
  localparam int ST_TIR     = ST_SIN2T + 1;
  localparam int ST_COST0   = ST_TIR + 1;
  localparam int COST_STEPS = 17;
  localparam int ST_FPROD   = ST_COST0 + COST_STEPS;
  localparam int ST_FINIT   = ST_FPROD + 1;
  localparam int ST_F0      = ST_FINIT + 1;
  localparam int ST_TPROD   = ST_F0;
  localparam int ST_TSUM    = ST_F0 + 1;
  localparam int ST_RSQ     = ST_F0 + QBITS;
  localparam int ST_REFL    = ST_RSQ + 1;
  localparam int ST_OUT     = ST_REFL + 1;
  localparam int PIPE_DEPTH = ST_OUT + 1;

  typedef logic signed [18:0] dv_t;
  typedef logic signed [17:0] q18_t;
  typedef logic signed [36:0] prod_t;
  typedef logic signed [56:0] sn_t;
  typedef logic signed [22:0] w_t;
  typedef logic signed [37:0] ed_t;
  typedef logic signed [43:0] kn_t;

  typedef struct packed {
    logic               valid;
    logic [15:0]        rnd;
    dv_t  [2:0]         d;
    q18_t [2:0]         n;
    prod_t [2:0]        p;
    logic signed [38:0] s;
    logic               leaving;
    logic [20:0]        c;
    logic [13:0]        ei;
    logic [13:0]        et;
    logic [29:0]        eta_rem;
    logic [17:0]        eta_q;
    sn_t  [2:0]         sn;
    w_t   [2:0]         w;
    logic [16:0]        sin2i;
    logic [2:0][44:0]   ww;
    logic [45:0]        sq1_x;
    logic [45:0]        sq1_r;
    logic [22:0]        len;
    logic [2:0][38:0]   nrem;
    logic [2:0][16:0]   nq;
    q18_t [2:0]         rv;
    logic [19:0]        eta2;
    logic [20:0]        sin2t;
    logic               tir;
    logic [33:0]        sq2_x;
    logic [33:0]        sq2_r;
    logic [16:0]        cost;
    logic [34:0]        ra;
    logic [30:0]        rb;
    logic [34:0]        rc;
    logic [30:0]        rd;
    logic [38:0]        etac;
    logic [1:0][52:0]   frem;
    logic [1:0][35:0]   fden;
    logic [1:0][16:0]   fq;
    logic [1:0]         fzero;
    logic signed [24:0] kk;
    ed_t  [2:0]         ed;
    kn_t  [2:0]         kn;
    q18_t [2:0]         tv;
    logic [34:0]        rsum;
    logic [16:0]        refl;
    logic               reflect;
    q18_t [2:0]         ov;
  } pipe_t;

  // Work of pipeline stage k on the beat held by stage k-1
  function automatic pipe_t stage_step(input int k, input pipe_t p,
                                       input logic [13:0] io, input logic [13:0] ii);
    pipe_t              r;
    int                 bit_i;
    int                 j;
    logic [38:0]        abs_s;
    logic [42:0]        csq;
    logic [26:0]        c2;
    logic signed [58:0] tw;
    logic signed [45:0] sqw;
    logic [45:0]        b1;
    logic [45:0]        t1;
    logic [33:0]        b2;
    logic [33:0]        t2;
    logic [63:0]        shd;
    logic [21:0]        mag;
    logic signed [17:0] qs;
    logic [35:0]        ee;
    logic [36:0]        st;
    logic [35:0]        fa;
    logic [35:0]        fb;
    logic [35:0]        fnum;
    logic [39:0]        ec;
    logic signed [18:0] nn;
    logic signed [18:0] etas;
    logic signed [45:0] tsum;
    logic signed [45:0] tsh;
    logic [16:0]        rp0;
    logic [16:0]        rp1;
    logic [34:0]        rs;
    r = p;

    // Component products of the dot product
    if (k == ST_PROD) begin
      for (int i = 0; i < 3; i++) r.p[i] = p.d[i] * p.n[i];
    end

    if (k == ST_SUM) begin
      r.s = 39'(p.p[0]) + 39'(p.p[1]) + 39'(p.p[2]);
    end

    // Pick side, round cosine, seed the index ratio divide
    if (k == ST_SIDE) begin
      abs_s     = (p.s < 0) ? 39'(-p.s) : 39'(p.s);
      r.leaving = (p.s > 0);
      r.c       = 21'((abs_s + 39'd32768) >> 16);
      r.ei      = (p.s > 0) ? ii : io;
      r.et      = (p.s > 0) ? io : ii;
      r.eta_rem = {r.ei, 16'd0} + 30'(r.et >> 1);
      r.eta_q   = '0;
    end

    // One quotient bit of eta per stage
    if (k >= ST_ETA0 && k < ST_ETA0 + ETA_BITS) begin
      bit_i = ST_ETA0 + ETA_BITS - 1 - k;
      shd   = 64'(p.et) << bit_i;
      if (64'(p.eta_rem) >= shd) begin
        r.eta_rem      = 30'(64'(p.eta_rem) - shd);
        r.eta_q[bit_i] = 1'b1;
      end
    end

    if (k == ST_SN) begin
      for (int i = 0; i < 3; i++) r.sn[i] = p.s * p.n[i];
    end

    // Mirror vector and sin^2 of incidence
    if (k == ST_W) begin
      for (int i = 0; i < 3; i++) begin
        tw     = 59'sd2147483648 - (59'(p.sn[i]) <<< 1);
        r.w[i] = w_t'(p.d[i]) + w_t'(tw >>> 32);
      end
      csq     = 43'(p.c) * 43'(p.c) + 43'd32768;
      c2      = csq[42:16];
      r.sin2i = (c2 >= 27'd65536) ? 17'd0 : 17'(27'd65536 - c2);
    end

    if (k == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sqw     = 46'(p.w[i]) * 46'(p.w[i]);
        r.ww[i] = sqw[44:0];
      end
    end

    if (k == ST_LEN2) begin
      r.sq1_x = 46'(p.ww[0]) + 46'(p.ww[1]) + 46'(p.ww[2]);
      r.sq1_r = '0;
    end

    // One root digit of the mirror length per stage
    if (k >= ST_LEN0 && k < ST_LEN0 + LEN_STEPS) begin
      j  = k - ST_LEN0;
      b1 = 46'(1) << (44 - 2 * j);
      t1 = p.sq1_r + b1;
      if (p.sq1_x >= t1) begin
        r.sq1_x = p.sq1_x - t1;
        r.sq1_r = (p.sq1_r >> 1) + b1;
      end else begin
        r.sq1_r = p.sq1_r >> 1;
      end
    end

    // Seed the three normalizing divides
    if (k == ST_NINIT) begin
      r.len = p.sq1_r[22:0];
      for (int i = 0; i < 3; i++) begin
        mag       = (p.w[i] < 0) ? 22'(-p.w[i]) : 22'(p.w[i]);
        r.nrem[i] = {1'b0, mag, 16'd0} + 39'(r.len >> 1);
        r.nq[i]   = '0;
      end
    end

    if (k >= ST_N0 && k < ST_N0 + QBITS) begin
      bit_i = ST_N0 + QBITS - 1 - k;
      shd   = 64'(p.len) << bit_i;
      for (int i = 0; i < 3; i++) begin
        if (64'(p.nrem[i]) >= shd) begin
          r.nrem[i]        = 39'(64'(p.nrem[i]) - shd);
          r.nq[i][bit_i]   = 1'b1;
        end
      end
    end

    // Restore signs; a zero-length mirror vector gives zero
    if (k == ST_NFIN) begin
      for (int i = 0; i < 3; i++) begin
        qs      = $signed({1'b0, p.nq[i]});
        r.rv[i] = (p.len == '0) ? '0 : ((p.w[i] < 0) ? -qs : qs);
      end
    end

    if (k == ST_ETA2) begin
      ee     = 36'(p.eta_q) * 36'(p.eta_q) + 36'd32768;
      r.eta2 = ee[35:16];
    end

    if (k == ST_SIN2T) begin
      st      = 37'(p.eta2) * 37'(p.sin2i) + 37'd32768;
      r.sin2t = st[36:16];
    end

    // Flag total internal reflection, seed the cosine root
    if (k == ST_TIR) begin
      r.tir   = (p.sin2t >= 21'd65536);
      r.sq2_x = r.tir ? '0 : 34'({17'(21'd65536 - p.sin2t), 16'd0});
      r.sq2_r = '0;
    end

    if (k >= ST_COST0 && k < ST_COST0 + COST_STEPS) begin
      j  = k - ST_COST0;
      b2 = 34'(1) << (32 - 2 * j);
      t2 = p.sq2_r + b2;
      if (p.sq2_x >= t2) begin
        r.sq2_x = p.sq2_x - t2;
        r.sq2_r = (p.sq2_r >> 1) + b2;
      end else begin
        r.sq2_r = p.sq2_r >> 1;
      end
    end

    // Fresnel terms and refraction scale
    if (k == ST_FPROD) begin
      r.cost = p.sq2_r[16:0];
      r.ra   = 35'(p.et) * 35'(p.c);
      r.rb   = 31'(p.ei) * 31'(r.cost);
      r.rc   = 35'(p.ei) * 35'(p.c);
      r.rd   = 31'(p.et) * 31'(r.cost);
      r.etac = 39'(p.eta_q) * 39'(p.c);
    end

    if (k == ST_FINIT) begin
      for (int m = 0; m < 2; m++) begin
        fa         = (m == 0) ? 36'(p.ra) : 36'(p.rc);
        fb         = (m == 0) ? 36'(p.rb) : 36'(p.rd);
        fnum       = (fa > fb) ? (fa - fb) : (fb - fa);
        r.fden[m]  = fa + fb;
        r.fzero[m] = ((fa + fb) == '0);
        r.frem[m]  = {1'b0, fnum, 16'd0} + 53'((fa + fb) >> 1);
        r.fq[m]    = '0;
      end
      ec   = 40'(p.etac) + 40'd32768;
      r.kk = $signed({1'b0, ec[39:16]}) - $signed({8'd0, p.cost});
    end

    if (k >= ST_F0 && k < ST_F0 + QBITS) begin
      bit_i = ST_F0 + QBITS - 1 - k;
      for (int m = 0; m < 2; m++) begin
        shd = 64'(p.fden[m]) << bit_i;
        if (64'(p.frem[m]) >= shd) begin
          r.frem[m]        = 53'(64'(p.frem[m]) - shd);
          r.fq[m][bit_i]   = 1'b1;
        end
      end
    end

    // Refraction vector
    if (k == ST_TPROD) begin
      etas = $signed({1'b0, p.eta_q});
      for (int i = 0; i < 3; i++) begin
        nn      = p.leaving ? -19'(p.n[i]) : 19'(p.n[i]);
        r.ed[i] = etas * p.d[i];
        r.kn[i] = p.kk * nn;
      end
    end

    if (k == ST_TSUM) begin
      for (int i = 0; i < 3; i++) begin
        tsum    = 46'(p.ed[i]) + 46'(p.kn[i]) + 46'sd32768;
        tsh     = tsum >>> 16;
        r.tv[i] = (tsh > 46'sd131071) ? 18'sd131071 :
                  (tsh < -46'sd131072) ? -18'sd131072 : q18_t'(tsh);
      end
    end

    // Zero denominators count as full ratio
    if (k == ST_RSQ) begin
      rp0    = p.fzero[0] ? 17'd65536 : p.fq[0];
      rp1    = p.fzero[1] ? 17'd65536 : p.fq[1];
      r.rsum = 35'(rp0) * 35'(rp0) + 35'(rp1) * 35'(rp1);
    end

    if (k == ST_REFL) begin
      rs        = p.rsum + 35'd65536;
      r.refl    = p.tir ? 17'd65536 : 17'(rs >> 17);
      r.reflect = ({1'b0, p.rnd} <= r.refl);
    end

    if (k == ST_OUT) begin
      for (int i = 0; i < 3; i++) r.ov[i] = p.reflect ? p.rv[i] : p.tv[i];
    end

    return r;
  endfunction

endpackage

[hdl/dielectric_specular_scatter.sv]
// Throughput: one ray per cycle; busy stays low, start is taken every cycle.
// Latency is set by the refraction side: 18 eta quotient bits, 17 cosine root digits
// and 17 Fresnel quotient bits, each in a stage of its own.
// Reset (rst_n low, synchronous) empties the pipeline and restores both indices.
module dielectric_specular_scatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [17:0] in_dir_x,
  input  logic [17:0] in_dir_y,
  input  logic [17:0] in_dir_z,
  input  logic [17:0] in_normal_x,
  input  logic [17:0] in_normal_y,
  input  logic [17:0] in_normal_z,
  input  logic [15:0] in_random_fraction,
  output logic        out_valid,
  output logic [17:0] out_x,
  output logic [17:0] out_y,
  output logic [17:0] out_z,
  output logic        out_took_reflection,
  output logic [16:0] out_reflectance,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [13:0] cfg_wdata
);

  logic [13:0] ior_outside_r;
  logic [13:0] ior_inside_r;
  logic [13:0] io_eff;
  logic [13:0] ii_eff;

  dss_pkg::pipe_t pipe_r   [dss_pkg::PIPE_DEPTH];
  dss_pkg::pipe_t pipe_nxt [dss_pkg::PIPE_DEPTH];

  // The pipeline never stalls
  assign busy = 1'b0;

  // Clamp indices below 1.0
  assign io_eff = (ior_outside_r < dss_pkg::IOR_MIN) ? dss_pkg::IOR_MIN : ior_outside_r;
  assign ii_eff = (ior_inside_r < dss_pkg::IOR_MIN) ? dss_pkg::IOR_MIN : ior_inside_r;

  // Capture the incoming beat, negating the direction
  always_comb begin
    pipe_nxt[0]       = '0;
    pipe_nxt[0].valid = start & ~busy;
    pipe_nxt[0].rnd   = in_random_fraction;
    pipe_nxt[0].d[0]  = -dss_pkg::dv_t'($signed(in_dir_x));
    pipe_nxt[0].d[1]  = -dss_pkg::dv_t'($signed(in_dir_y));
    pipe_nxt[0].d[2]  = -dss_pkg::dv_t'($signed(in_dir_z));
    pipe_nxt[0].n[0]  = $signed(in_normal_x);
    pipe_nxt[0].n[1]  = $signed(in_normal_y);
    pipe_nxt[0].n[2]  = $signed(in_normal_z);
  end

  // Remaining stages
  for (genvar g = 1; g < dss_pkg::PIPE_DEPTH; g++) begin : g_stage
    assign pipe_nxt[g] = dss_pkg::stage_step(g, pipe_r[g-1], io_eff, ii_eff);
  end

  // Advance the pipeline, take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ior_outside_r <= dss_pkg::IOR_OUTSIDE_RST;
      ior_inside_r  <= dss_pkg::IOR_INSIDE_RST;
      for (int k = 0; k < dss_pkg::PIPE_DEPTH; k++) pipe_r[k].valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          dss_pkg::CFG_IOR_OUTSIDE: ior_outside_r <= cfg_wdata;
          dss_pkg::CFG_IOR_INSIDE:  ior_inside_r  <= cfg_wdata;
          default: ;
        endcase
      end
      for (int k = 0; k < dss_pkg::PIPE_DEPTH; k++) pipe_r[k] <= pipe_nxt[k];
    end
  end

  // Drive the result beat from the last stage
  assign out_valid           = pipe_r[dss_pkg::PIPE_DEPTH-1].valid;
  assign out_x               = pipe_r[dss_pkg::PIPE_DEPTH-1].ov[0];
  assign out_y               = pipe_r[dss_pkg::PIPE_DEPTH-1].ov[1];
  assign out_z               = pipe_r[dss_pkg::PIPE_DEPTH-1].ov[2];
  assign out_took_reflection = pipe_r[dss_pkg::PIPE_DEPTH-1].reflect;
  assign out_reflectance     = pipe_r[dss_pkg::PIPE_DEPTH-1].refl;

endmodule

[hdl/dss_checker.sv]
module dss_sva (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_random_fraction,
  input logic        out_valid,
  input logic        out_took_reflection,
  input logic [16:0] out_reflectance
);

  // Every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(dss_pkg::PIPE_DEPTH) out_valid)
    else $error("accepted beat did not emerge");

  // No result without a beat accepted one latency earlier
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, dss_pkg::PIPE_DEPTH))
    else $error("result without accepted beat");

  // Reflectance never exceeds 1.0
  a_refl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= 17'd65536)
    else $error("reflectance out of range");

  // Choice follows the random fraction of the same beat
  a_choice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, $past(in_random_fraction, dss_pkg::PIPE_DEPTH)}
                    <= out_reflectance) == out_took_reflection))
    else $error("reflect/refract choice mismatch");

endmodule

bind dielectric_specular_scatter dss_sva u_dss_sva (.*);

[bench/dss_checker.sv]
module dss_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [17:0] in_dir_x,
  input  logic [17:0] in_dir_y,
  input  logic [17:0] in_dir_z,
  input  logic [17:0] in_normal_x,
  input  logic [17:0] in_normal_y,
  input  logic [17:0] in_normal_z,
  input  logic [15:0] in_random_fraction,
  input  logic        out_valid,
  input  logic [17:0] out_x,
  input  logic [17:0] out_y,
  input  logic [17:0] out_z,
  input  logic        out_took_reflection,
  input  logic [16:0] out_reflectance,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [13:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [17:0] x;
    logic [17:0] y;
    logic [17:0] z;
    logic        refl_taken;
    logic [16:0] refl;
  } scatter_t;

  scatter_t    scatter_q[$];
  logic [13:0] ior_out_r;
  logic [13:0] ior_in_r;

  // Floor-division rounding helper: floor((x + 2^(sh-1)) / 2^sh)
  function automatic longint rnd_shift(longint x, int sh);
    longint t;
    t = x + (longint'(1) << (sh - 1));
    return t >>> sh;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned fresnel_ratio(longint unsigned a, longint unsigned b);
    longint unsigned num, den;
    num = (a > b) ? a - b : b - a;
    den = a + b;
    if (den == 0) return 64'd65536;
    return (num * 65536 + den / 2) / den;
  endfunction

  function automatic longint clamp18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic scatter_t predict_scatter(logic [17:0] dx, logic [17:0] dy,
                                               logic [17:0] dz, logic [17:0] nx,
                                               logic [17:0] ny, logic [17:0] nz,
                                               logic [15:0] frac);
    scatter_t        r;
    longint          d[3], n[3], w[3], v[3];
    longint          s, k, q;
    longint unsigned io, ii, ei, et, c, eta, eta2, c2, sin2i, sin2t, cost, refl;
    longint unsigned rpar, rperp, len2, len, mag;
    bit              leaving, take;
    d[0] = -longint'($signed(dx));
    d[1] = -longint'($signed(dy));
    d[2] = -longint'($signed(dz));
    n[0] = longint'($signed(nx));
    n[1] = longint'($signed(ny));
    n[2] = longint'($signed(nz));
    io = 64'((ior_out_r < dss_pkg::IOR_MIN) ? dss_pkg::IOR_MIN : ior_out_r);
    ii = 64'((ior_in_r < dss_pkg::IOR_MIN) ? dss_pkg::IOR_MIN : ior_in_r);
    s = 0;
    for (int i = 0; i < 3; i++) s += d[i] * n[i];
    leaving = s > 0;
    c = rnd_shift(s < 0 ? -s : s, 16);
    ei = leaving ? ii : io;
    et = leaving ? io : ii;
    eta = (ei * 65536 + et / 2) / et;
    eta2 = (eta * eta + 32768) >> 16;
    c2 = (c * c + 32768) >> 16;
    sin2i = (c2 >= 65536) ? 0 : 65536 - c2;
    sin2t = (eta2 * sin2i + 32768) >> 16;
    // Total internal reflection forces full reflectance
    if (sin2t >= 65536) begin
      cost = 0;
      refl = 65536;
    end else begin
      cost = int_sqrt((65536 - sin2t) << 16);
      rpar = fresnel_ratio(et * c, ei * cost);
      rperp = fresnel_ratio(ei * c, et * cost);
      refl = (rpar * rpar + rperp * rperp + 65536) >> 17;
    end
    take = 64'(frac) <= refl;
    if (take) begin
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        w[i] = rnd_shift((d[i] <<< 32) - 2 * s * n[i], 32);
        len2 += w[i] * w[i];
      end
      len = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          v[i] = 0;
        end else begin
          mag = (w[i] < 0) ? -w[i] : w[i];
          q = (mag * 65536 + len / 2) / len;
          v[i] = clamp18(w[i] < 0 ? -q : q);
        end
      end
    end else begin
      k = rnd_shift(longint'(eta * c), 16) - longint'(cost);
      for (int i = 0; i < 3; i++)
        v[i] = clamp18(rnd_shift(longint'(eta) * d[i] + k * (leaving ? -n[i] : n[i]), 16));
    end
    r.x = v[0][17:0];
    r.y = v[1][17:0];
    r.z = v[2][17:0];
    r.refl_taken = take;
    r.refl = refl[16:0];
    return r;
  endfunction

  assign pending = scatter_q.size();

  always @(posedge clk) begin
    scatter_t e;
    if (!rst_n) begin
      ior_out_r <= dss_pkg::IOR_OUTSIDE_RST;
      ior_in_r  <= dss_pkg::IOR_INSIDE_RST;
      scatter_q.delete();
      fail_count <= 0;
    end else begin
      // Predict each accepted beat with the indices in force
      if (start && !busy)
        scatter_q.push_back(predict_scatter(in_dir_x, in_dir_y, in_dir_z, in_normal_x,
                                            in_normal_y, in_normal_z, in_random_fraction));
      if (cfg_we) begin
        if (cfg_addr == dss_pkg::CFG_IOR_OUTSIDE) ior_out_r <= cfg_wdata;
        else ior_in_r <= cfg_wdata;
      end
      // Compare each result beat with the oldest prediction
      if (out_valid) begin
        if (scatter_q.size() == 0) begin
          $display("%0t: unexpected result beat", $time);
          fail_count <= fail_count + 1;
        end else begin
          e = scatter_q.pop_front();
          if (e.x !== out_x || e.y !== out_y || e.z !== out_z ||
              e.refl_taken !== out_took_reflection || e.refl !== out_reflectance) begin
            $display("%0t: mismatch exp x=%h y=%h z=%h refl=%b r=%h act x=%h y=%h z=%h refl=%b r=%h",
                     $time, e.x, e.y, e.z, e.refl_taken, e.refl, out_x, out_y, out_z,
                     out_took_reflection, out_reflectance);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[bench/tb_dielectric_specular_scatter.sv]
module tb_dielectric_specular_scatter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = dss_pkg::PIPE_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [17:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [17:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic [15:0] in_random_fraction = '0;
  logic        out_valid;
  logic [17:0] out_x, out_y, out_z;
  logic        out_took_reflection;
  logic [16:0] out_reflectance;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = dss_pkg::CFG_IOR_OUTSIDE;
  logic [13:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  always #5 clk = ~clk;

  dielectric_specular_scatter dut (.*);
  dss_checker chk (.*);

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one ray and hold it until accepted, then idle for the gap the caller gives
  task automatic send_ray(logic [17:0] dx, logic [17:0] dy, logic [17:0] dz,
                          logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                          logic [15:0] frac, int gap);
    start <= 1'b1;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    in_normal_x <= nx;
    in_normal_y <= ny;
    in_normal_z <= nz;
    in_random_fraction <= frac;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_write(logic addr, logic [13:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [17:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 18'($urandom_range(0, 131072) - 65536);
      1: return 18'($urandom);
      2: return 18'($urandom_range(0, 1) ? 65536 : -65536);
      default: return 18'($urandom_range(0, 40000) - 20000);
    endcase
  endfunction

  // Send a ray with a roughly unit normal (now and then a random one) and a random direction
  task automatic random_ray(bit gaps);
    int ax, gap;
    logic [17:0] n[3], dv[3];
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      n[i] = (i == ax) ? 18'($urandom_range(0, 1) ? 65536 : -65536)
                       : 18'($urandom_range(0, 8000) - 4000);
      dv[i] = rand_comp();
    end
    if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 3; i++) n[i] = 18'($urandom);
    gap = gaps ? $urandom_range(0, 4) : 0;
    send_ray(dv[0], dv[1], dv[2], n[0], n[1], n[2], 16'($urandom), gap);
  endtask

  initial begin
    logic [13:0] iors[6][2];
    iors = '{'{14'd4096, 14'd6144}, '{14'd16383, 14'd4096}, '{14'd0, 14'd16383},
             '{14'd6144, 14'd4095}, '{14'd4096, 14'd16383}, '{14'd5000, 14'd9000}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: axis hits both sides, grazing, zero vectors, field extremes
    send_ray(-18'sd65536, 18'd0, 18'd0, 18'sd65536, 18'd0, 18'd0, 16'd0, 0);
    send_ray(18'sd65536, 18'd0, 18'd0, 18'sd65536, 18'd0, 18'd0, 16'hFFFF, 1);
    send_ray(18'sd65536, 18'd0, 18'd0, 18'd0, 18'sd65536, 18'd0, 16'hFFFF, 0);
    send_ray(18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'sd65536, 16'd0, 2);
    send_ray(18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 16'hFFFF, 0);
    send_ray(18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000, 16'h8000, 0);
    send_ray(18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 18'h20000, 16'd1, 3);
    send_ray(-18'sd46341, -18'sd46341, 18'd0, 18'd0, 18'sd65536, 18'd0, 16'd3000, 0);
    send_ray(18'sd46341, 18'sd46341, 18'd0, 18'd0, 18'sd65536, 18'd0, 16'd60000, 0);
    send_ray(18'sd60000, 18'sd20000, 18'd0, 18'd0, 18'sd65536, 18'd0, 16'hFFFF, 4);
    send_ray(-18'sd65536, 18'd0, 18'd0, 18'sd65536, 18'd0, 18'd0, 16'hFFFF, 0);
    send_ray(18'sd65536, 18'sd65536, 18'sd65536, -18'sd65536, -18'sd65536, -18'sd65536,
             16'h7FFF, 0);
    // Random phases across index settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write(dss_pkg::CFG_IOR_OUTSIDE, iors[ph][0]);
      drain_and_write(dss_pkg::CFG_IOR_INSIDE, iors[ph][1]);
      for (int i = 0; i < 256; i++) random_ray((i / 64) % 2 == 1);
    end
    // Wait out the tail
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
hdl/dss_pkg.sv
hdl/dielectric_specular_scatter.sv
hdl/dss_checker.sv
bench/dss_checker.sv
bench/tb_dielectric_specular_scatter.sv
